@@ hw/rtl/rbc_pkg.sv @@
package rbc_pkg;

  localparam int AccWidth      = 64;
  localparam int BitCntWidth   = $clog2(AccWidth);
  localparam int BaseWidth     = 6;
  localparam int DigitWidth    = 6;
  localparam int CharWidth     = 7;
  localparam int MaxDigitsDef  = 64;
  localparam int CaseFold      = 207 - 175;
  localparam int SourceBaseRst = 10;
  localparam int TargetBaseRst = 10;
  localparam int MinBase       = 2;
  localparam int MaxBase       = 36;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StStore,
    StRead,
    StOut
  } rbc_state_e;

  typedef struct packed {
    logic acc_en;
    logic conv_start;
    logic div_step;
    logic digit_wr;
    logic rd_en;
  } rbc_cmd_t;

  typedef struct packed {
    logic bit_last;
    logic quot_zero;
    logic out_last;
  } rbc_sts_t;

  // fold lower case, then map to digit value; values below '0' wrap
  function automatic logic [AccWidth-1:0] char_value(input logic [7:0] c);
    logic [7:0] f;
    f = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      f = c - 8'(CaseFold);
    end
    if (f >= 8'h41) begin
      char_value = AccWidth'(f) - AccWidth'(55);
    end else begin
      char_value = AccWidth'(f) - AccWidth'(48);
    end
  endfunction

  // digit value to ASCII '0'-'9' / 'A'-'Z'
  function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d);
    logic [DigitWidth-1:0] dc;
    dc = (d > DigitWidth'(35)) ? DigitWidth'(35) : d;
    if (dc < DigitWidth'(10)) begin
      digit_char = CharWidth'(8'h30) + CharWidth'(dc);
    end else begin
      digit_char = CharWidth'(8'h37) + CharWidth'(dc);
    end
  endfunction

endpackage

@@ hw/rtl/radix_base_converter_unit.sv @@
// non-last character: accepted in the idle state, next character the cycle after
// conversion: per output digit, a 64-step bit-serial divider plus a store
// emission: a registered digit-store read, then the digit is offered until taken; MSD first
// no new character is taken while a number is being converted or emitted
// async active-low reset clears total, counters and state; bases reset to 10
module radix_base_converter_unit import rbc_pkg::*; #(
  parameter int MaxDigits = MaxDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic        m_axis_tlast,   // last_digit
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rbc_cmd_t             cmd;
  rbc_sts_t             sts;
  logic [BaseWidth-1:0] source_base;
  logic [BaseWidth-1:0] target_base;
  logic [CharWidth-1:0] out_char;

  rbc_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .source_base_o (source_base),
    .target_base_o (target_base)
  );

  rbc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rbc_dp #(
    .MaxDigits (MaxDigits)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_char_i     (s_axis_tdata),
    .source_base_i (source_base),
    .target_base_i (target_base),
    .out_char_o    (out_char),
    .last_digit_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

@@ hw/rtl/rbc_cfg.sv @@
module rbc_cfg import rbc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output logic [BaseWidth-1:0] source_base_o,
  output logic [BaseWidth-1:0] target_base_o
);

  logic [BaseWidth-1:0] source_base_q, source_base_d;
  logic [BaseWidth-1:0] target_base_q, target_base_d;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    source_base_d = source_base_q;
    target_base_d = target_base_q;
    if (wr_en) begin
      if (paddr[2]) begin
        target_base_d = pwdata[BaseWidth-1:0];
      end else begin
        source_base_d = pwdata[BaseWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_base_q <= BaseWidth'(SourceBaseRst);
      target_base_q <= BaseWidth'(TargetBaseRst);
    end else begin
      source_base_q <= source_base_d;
      target_base_q <= target_base_d;
    end
  end

  assign prdata        = paddr[2] ? 32'(target_base_q) : 32'(source_base_q);
  assign source_base_o = source_base_q;
  assign target_base_o = target_base_q;

endmodule

@@ hw/rtl/rbc_ctrl.sv @@
module rbc_ctrl import rbc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  input  logic     s_last_i,
  output logic     s_ready_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  input  rbc_sts_t sts_i,
  output rbc_cmd_t cmd_o
);

  rbc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.acc_en = 1'b1;
          if (s_last_i) begin
            cmd_o.conv_start = 1'b1;
            state_d          = StDiv;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.bit_last) begin
          state_d = StStore;
        end
      end
      StStore: begin
        cmd_o.digit_wr = 1'b1;
        state_d = sts_i.quot_zero ? StRead : StDiv;
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StOut;
      end
      StOut: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          state_d = sts_i.out_last ? StIdle : StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // input side and output side never open at once
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_ready_o && m_valid_o))
    else $error("input and output open together");

endmodule

@@ hw/rtl/rbc_dp.sv @@
module rbc_dp import rbc_pkg::*; #(
  parameter int MaxDigits = MaxDigitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rbc_cmd_t             cmd_i,
  output rbc_sts_t             sts_o,
  input  logic [7:0]           in_char_i,
  input  logic [BaseWidth-1:0] source_base_i,
  input  logic [BaseWidth-1:0] target_base_i,
  output logic [CharWidth-1:0] out_char_o,
  output logic                 last_digit_o
);

  localparam int CntWidth  = $clog2(MaxDigits + 1);
  localparam int AddrWidth = $clog2(MaxDigits);

  logic [AccWidth-1:0]    acc_q, acc_d;
  logic [DigitWidth-1:0]  rem_q, rem_d;
  logic [BitCntWidth-1:0] bitcnt_q, bitcnt_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic                   last_q, last_d;
  logic [DigitWidth-1:0]  rd_data_q;
  logic [DigitWidth-1:0]  digit_mem [MaxDigits];

  logic [BaseWidth-1:0]   base;
  logic [DigitWidth:0]    trial;
  logic                   qbit;
  logic [AddrWidth-1:0]   rd_addr;
  logic [CntWidth-1:0]    cnt_dec;

  // target base clamped into 2..36
  always_comb begin
    base = target_base_i;
    if (target_base_i < BaseWidth'(MinBase)) begin
      base = BaseWidth'(MinBase);
    end else if (target_base_i > BaseWidth'(MaxBase)) begin
      base = BaseWidth'(MaxBase);
    end
  end

  // one restoring division bit per cycle, dividend shifts out of acc
  assign trial = {rem_q, acc_q[AccWidth-1]};
  assign qbit  = trial >= {1'b0, base};

  assign cnt_dec = cnt_q - CntWidth'(1);
  assign rd_addr = cnt_dec[AddrWidth-1:0];

  always_comb begin
    acc_d    = acc_q;
    rem_d    = rem_q;
    bitcnt_d = bitcnt_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    if (cmd_i.acc_en) begin
      acc_d = acc_q * {{(AccWidth-BaseWidth){1'b0}}, source_base_i} + char_value(in_char_i);
    end
    if (cmd_i.conv_start) begin
      rem_d    = '0;
      bitcnt_d = '0;
      cnt_d    = '0;
    end
    if (cmd_i.div_step) begin
      acc_d    = {acc_q[AccWidth-2:0], qbit};
      rem_d    = qbit ? DigitWidth'(trial - {1'b0, base}) : trial[DigitWidth-1:0];
      bitcnt_d = bitcnt_q + BitCntWidth'(1);
    end
    if (cmd_i.digit_wr) begin
      rem_d = '0;
      if (cnt_q < CntWidth'(MaxDigits)) begin
        cnt_d = cnt_q + CntWidth'(1);
      end
    end
    if (cmd_i.rd_en) begin
      cnt_d  = cnt_dec;
      last_d = cnt_q == CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      bitcnt_q <= '0;
      cnt_q    <= '0;
      last_q   <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      bitcnt_q <= bitcnt_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  // digit store, least significant first; read back from the top
  always_ff @(posedge clk_i) begin
    if (cmd_i.digit_wr && cnt_q < CntWidth'(MaxDigits)) begin
      digit_mem[cnt_q[AddrWidth-1:0]] <= rem_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= digit_mem[rd_addr];
    end
  end

  assign sts_o.bit_last  = bitcnt_q == '1;
  assign sts_o.quot_zero = acc_q == '0;
  assign sts_o.out_last  = last_q;

  assign out_char_o   = digit_char(rd_data_q);
  assign last_digit_o = last_q;

  a_rem_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> rem_q < base)
    else $error("partial remainder not below base");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> cnt_q != '0)
    else $error("digit read with empty store");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.digit_wr && cnt_q < CntWidth'(MaxDigits)) |=> cnt_q == $past(cnt_q) + CntWidth'(1))
    else $error("digit count did not advance");

endmodule

@@ bench/rbc_digit_checker.sv @@
module rbc_digit_checker import rbc_pkg::*; #(
  parameter logic [2:0] SrcBaseAddr = 3'd0,
  parameter logic [2:0] DstBaseAddr = 3'd4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // last_char
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [6:0] out_char, [7] zero
  input  logic        m_axis_tlast,   // last_digit
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches_o,
  output int          digits_due_o
);

  typedef struct packed {
    logic [CharWidth-1:0] glyph;
    logic                 final_digit;
  } digit_t;

  logic [AccWidth-1:0]  running_total;
  logic [BaseWidth-1:0] src_base;
  logic [BaseWidth-1:0] dst_base;
  digit_t               digits_due [$];
  int                   mismatches;

  assign mismatches_o = mismatches;

  // lower case folds to upper case first, then letters weigh c - 55
  function automatic logic [AccWidth-1:0] char_weight(input logic [7:0] c);
    logic [7:0] f;
    f = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      f = c - 8'(CaseFold);
    end
    if (f >= 8'h41) begin
      return AccWidth'(f) - AccWidth'(55);
    end
    return AccWidth'(f) - AccWidth'(48);
  endfunction

  // splits the total into target-base digits, queued most significant first
  task automatic convert_total();
    logic [AccWidth-1:0]   v;
    logic [AccWidth-1:0]   radix;
    logic [DigitWidth-1:0] held [MaxDigitsDef];
    int                    cnt;
    digit_t                d;
    radix = AccWidth'(dst_base);
    if (radix < AccWidth'(MinBase)) begin
      radix = AccWidth'(MinBase);
    end
    if (radix > AccWidth'(MaxBase)) begin
      radix = AccWidth'(MaxBase);
    end
    v = running_total;
    cnt = 0;
    do begin
      if (cnt < MaxDigitsDef) begin
        held[cnt] = DigitWidth'(v % radix);
        cnt++;
      end
      v = v / radix;
    end while (v != 0);
    for (int k = cnt - 1; k >= 0; k--) begin
      d.glyph = (held[k] < 10) ? CharWidth'(48 + held[k]) : CharWidth'(55 + held[k]);
      d.final_digit = (k == 0);
      digits_due.push_back(d);
    end
    running_total = '0;
  endtask

  task automatic check_digit(input logic [7:0] data, input logic last);
    digit_t d;
    if (digits_due.size() == 0) begin
      if (mismatches < 10) begin
        $display("unexpected digit: char %h last %b", data, last);
      end
      mismatches++;
    end else begin
      d = digits_due.pop_front();
      if (data !== {1'b0, d.glyph} || last !== d.final_digit) begin
        if (mismatches < 10) begin
          $display("digit mismatch: expected char %h last %b, got char %h last %b",
                   {1'b0, d.glyph}, d.final_digit, data, last);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_total = '0;
      src_base = BaseWidth'(SourceBaseRst);
      dst_base = BaseWidth'(TargetBaseRst);
      digits_due.delete();
      mismatches = 0;
      digits_due_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == SrcBaseAddr) begin
          src_base = pwdata[BaseWidth-1:0];
        end else if (paddr == DstBaseAddr) begin
          dst_base = pwdata[BaseWidth-1:0];
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        running_total = running_total * AccWidth'(src_base) + char_weight(s_axis_tdata);
        if (s_axis_tlast) begin
          convert_total();
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_digit(m_axis_tdata, m_axis_tlast);
      end
      digits_due_o <= digits_due.size();
    end
  end

endmodule

@@ bench/radix_base_converter_unit_tb.sv @@
module radix_base_converter_unit_tb;
  import rbc_pkg::*;

  localparam logic [2:0] SrcBaseAddr = 3'd0;
  localparam logic [2:0] DstBaseAddr = 3'd4;
  localparam int         CycleLimit  = 4_000_000;
  localparam int         HoldCycles  = 300;
  localparam int         IdlePct     = 38;
  localparam int         NumPhases   = 12;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = '0;
  logic        s_last  = 1'b0;
  logic        m_ready = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;

  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int digits_due;
  int cycle_cnt;

  // receiver shaping; quiet and hold_asked are driven by the stimulus process
  logic quiet       = 1'b0;
  int   hold_asked  = 0;
  int   hold_served = 0;
  int   hold_left   = 0;

  // base sweep, extremes and out-of-range values included
  int src_sweep [NumPhases] = '{36, 2, 16, 0, 1, 37, 63, 8, 10, 2, 36, 7};
  int dst_sweep [NumPhases] = '{2, 36, 10, 63, 0, 1, 37, 16, 10, 2, 36, 3};

  radix_base_converter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  rbc_digit_checker #(
    .SrcBaseAddr (SrcBaseAddr),
    .DstBaseAddr (DstBaseAddr)
  ) u_digit_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches_o  (mismatches),
    .digits_due_o  (digits_due)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // digit sink: random stalls, quiet stretches and one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (hold_served != hold_asked && m_axis_tvalid) begin
        hold_served++;
        hold_left = HoldCycles;
        m_ready <= 1'b0;
      end else begin
        m_ready <= quiet || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= c;
    s_last  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // lets every queued digit drain, then waits for the unit to settle
  task automatic drain_digits();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (digits_due != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [BaseWidth-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {26'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly digits valid for the source base in either case, some raw bytes
  task automatic send_random_number(input int src, output int len);
    int            span;
    int            v;
    logic [7:0]    c;
    span = (src < MinBase) ? 10 : (src > MaxBase) ? MaxBase : src;
    len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 12) begin
        c = 8'($urandom_range(255));
      end else begin
        v = $urandom_range(span - 1);
        if (v < 10) begin
          c = 8'(48 + v);
        end else begin
          c = 8'(($urandom_range(1) ? 65 : 97) + v - 10);
        end
      end
      send_char(c, i == len - 1);
    end
  endtask

  initial begin
    int len;
    int phase_items;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset bases: single digits, short numbers, case folding, bytes above 127, wrap below '0'
    send_char("0", 1'b1);
    send_char("1", 1'b0);
    send_char("9", 1'b1);
    send_char("a", 1'b0);
    send_char("Z", 1'b1);
    send_char("A", 1'b0);
    send_char("z", 1'b1);
    send_char(8'hff, 1'b1);
    send_char(8'h80, 1'b1);
    send_char(8'h60, 1'b0);
    send_char(8'h7b, 1'b0);
    send_char(8'h40, 1'b1);
    send_char(8'h00, 1'b1);
    send_char("/", 1'b1);
    drain_digits();

    // binary target: wrapped total gives the longest digit run
    reg_write(DstBaseAddr, 6'd2);
    send_char(8'h00, 1'b1);
    send_char("1", 1'b1);
    drain_digits();

    for (int p = 0; p < NumPhases; p++) begin
      reg_write(SrcBaseAddr, BaseWidth'(src_sweep[p]));
      reg_write(DstBaseAddr, BaseWidth'(dst_sweep[p]));
      quiet <= (p == 5);
      if (p == 2) begin
        hold_asked <= hold_asked + 1;
      end
      phase_items = 0;
      while (phase_items < 8) begin
        send_random_number(src_sweep[p], len);
        phase_items += len;
      end
      drain_digits();
    end

    if (mismatches == 0 && digits_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
